/* design/alps_pkg.sv */
// shared types and constants for the arc length to parameter lookup
// no dependencies

package alps_pkg;

  localparam int LEN_W   = 31;
  localparam int PARAM_W = 17;
  localparam int PATCH_W = 8;
  localparam int TOL_W   = 16;
  localparam int QUOT_W  = 17;
  localparam int PROD_W  = LEN_W + PARAM_W;

  localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic [PARAM_W-1:0] param;
    logic [PATCH_W-1:0] patch;
  } entry_t;

endpackage

/* design/alps_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module alps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/alps_div.sv */
// restoring divider, one quotient bit per cycle
// uses alps_pkg; caller guarantees quotient fits in QUOT_W bits

module alps_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [alps_pkg::PROD_W-1:0] dividend,
  input  logic [alps_pkg::LEN_W-1:0]  divisor,
  output logic                       done,
  output logic [alps_pkg::QUOT_W-1:0] quotient
);
  import alps_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [LEN_W-1:0]  rem;
  logic [QUOT_W-1:0] shreg;
  logic [CNT_W-1:0]  cnt;
  logic              running;

  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             fits;
  logic [LEN_W-1:0] rem_next;

  // shift the next dividend bit in, subtract when it fits
  always_comb begin
    trial    = {rem, shreg[QUOT_W-1]};
    diff     = trial - {1'b0, divisor};
    fits     = trial >= {1'b0, divisor};
    rem_next = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // upper part is already below the divisor
        rem     <= dividend[PROD_W-1:QUOT_W];
        shreg   <= dividend[QUOT_W-1:0];
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem   <= rem_next;
        shreg <= {shreg[QUOT_W-2:0], fits};
        cnt   <= cnt + 1'b1;
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = shreg;

endmodule

/* design/arc_length_parameter_lookup.sv */
// arc length to curve parameter lookup: table store, binary search, interpolation
// uses alps_pkg, alps_ram (table store) and alps_div (interpolation fraction)
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  command  | start / busy              | opcode, arc_length, entry_param, entry_patch
//  result   | done (one cycle strobe)   | found_param, found_patch, status
//  config   | cfg_valid / cfg_ready     | cfg_data (near one tolerance)
//
// clear, append and rejected queries: result in the cycle after the transfer, busy stays low
// query: each binary search probe is a ram read, a compare and a neighbor read, at most
//   floor(log2(entries)) + 1 probes, the last of which can only be an exact hit;
//   interpolation then registers differences and product and waits on the serial divider
// busy stays high through a query; the next transfer is taken once busy is low again
// rst is synchronous and empties the table; the table ram itself is never cleared
// the receiver takes every result, so nothing stalls on the result side

module arc_length_parameter_lookup #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic signed [31:0]            arc_length,
  input  logic [alps_pkg::PARAM_W-1:0]  entry_param,
  input  logic [alps_pkg::PATCH_W-1:0]  entry_patch,
  output logic                          done,
  output logic [alps_pkg::PARAM_W-1:0]  found_param,
  output logic [alps_pkg::PATCH_W-1:0]  found_patch,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [alps_pkg::TOL_W-1:0]    cfg_data
);
  import alps_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PROBE, S_MID, S_NBR, S_LERP, S_MUL, S_DIVGO, S_DIV
  } state_t;

  state_t state;

  logic [TOL_W-1:0] tol;
  logic [CW-1:0]    count;
  logic [LEN_W-1:0] first_length;
  logic [LEN_W-1:0] last_length;

  logic [LEN_W-1:0] qlen;
  logic [AW-1:0]    lo;
  logic [AW-1:0]    hi;
  logic [AW-1:0]    mid;
  logic             dir_down;
  entry_t           mid_ent;
  entry_t           lo_ent;
  entry_t           hi_ent;

  logic [PARAM_W-1:0] pa;
  logic [LEN_W-1:0]   dlen;
  logic [LEN_W-1:0]   den;
  logic               dp_neg;
  logic [PARAM_W-1:0] dp_mag;
  logic [PROD_W-1:0]  prod;

  // accept and append datapath
  logic             accept;
  logic             full;
  logic             ram_we;
  entry_t           wr_ent;
  logic [LEN_W-1:0] app_len;
  logic [AW-1:0]    raddr;
  entry_t           rd;
  logic [AW-1:0]    mid_calc;
  logic [CW-1:0]    mid_plus;

  // interpolation datapath
  logic [PARAM_W:0]   band_lo;
  logic [PARAM_W:0]   band_hi;
  logic               in_band;
  logic [PARAM_W-1:0] pa_adj;
  logic [PARAM_W:0]   dp;
  logic [PROD_W-1:0]  prod_w;

  logic               div_start;
  logic               div_done;
  logic [QUOT_W-1:0]  quot;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign full      = (count >= CW'(TABLE_DEPTH));

  always_comb begin
    app_len = arc_length[31] ? '0 : arc_length[LEN_W-1:0];
    // keep the table non-decreasing
    if (count != '0 && app_len < last_length) begin
      app_len = last_length;
    end
    wr_ent.length = app_len;
    wr_ent.param  = (entry_param > ONE_Q16) ? ONE_Q16 : entry_param;
    wr_ent.patch  = entry_patch;
  end

  assign ram_we = accept && opcode == OP_APPEND && !full;

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign mid_plus = CW'(mid) + 1'b1;

  always_comb begin
    case (state)
      S_PROBE: raddr = mid_calc;
      S_MID:   raddr = (rd.length > qlen) ? mid - 1'b1 : AW'(mid_plus);
      default: raddr = mid;
    endcase
  end

  alps_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (wr_ent),
    .raddr (raddr),
    .rdata (rd)
  );

  // lower parameter near 1.0 counts as 0
  always_comb begin
    band_lo = {1'b0, ONE_Q16} - {2'b0, tol};
    band_hi = {1'b0, ONE_Q16} + {2'b0, tol};
    in_band = ({1'b0, lo_ent.param} >= band_lo) && ({1'b0, lo_ent.param} <= band_hi);
    pa_adj  = in_band ? '0 : lo_ent.param;
    dp      = {1'b0, hi_ent.param} - {1'b0, pa_adj};
    prod_w  = dlen * dp_mag;
  end

  assign div_start = (state == S_DIVGO);

  alps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tol   <= TOL_W'(66);
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        tol <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            found_param <= '0;
            found_patch <= '0;
            status      <= ST_OK;
            done        <= 1'b1;
            case (opcode)
              OP_CLEAR: begin
                count <= '0;
              end
              OP_APPEND: begin
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  if (count == '0) begin
                    first_length <= wr_ent.length;
                  end
                  last_length <= wr_ent.length;
                  count       <= count + 1'b1;
                end
              end
              OP_QUERY: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else if (arc_length[31] || arc_length[LEN_W-1:0] > last_length ||
                             arc_length[LEN_W-1:0] < first_length) begin
                  status <= ST_RANGE;
                end else begin
                  done  <= 1'b0;
                  qlen  <= arc_length[LEN_W-1:0];
                  lo    <= '0;
                  hi    <= AW'(count - 1'b1);
                  state <= S_PROBE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PROBE: begin
          if (lo > hi) begin
            status <= ST_RANGE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            mid   <= mid_calc;
            state <= S_MID;
          end
        end
        S_MID: begin
          mid_ent <= rd;
          if (rd.length == qlen) begin
            found_param <= rd.param;
            found_patch <= rd.patch;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else if (rd.length > qlen) begin
            dir_down <= 1'b1;
            if (mid == '0) begin
              status <= ST_RANGE;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_NBR;
            end
          end else begin
            dir_down <= 1'b0;
            if (mid_plus >= count) begin
              status <= ST_RANGE;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_NBR;
            end
          end
        end
        S_NBR: begin
          // rd holds the neighbor below or above the probe
          if (dir_down) begin
            if (rd.length < qlen) begin
              lo_ent      <= rd;
              hi_ent      <= mid_ent;
              found_patch <= mid_ent.patch;
              state       <= S_LERP;
            end else begin
              hi    <= mid - 1'b1;
              state <= S_PROBE;
            end
          end else begin
            if (rd.length > qlen) begin
              lo_ent      <= mid_ent;
              hi_ent      <= rd;
              found_patch <= rd.patch;
              state       <= S_LERP;
            end else begin
              lo    <= AW'(mid_plus);
              state <= S_PROBE;
            end
          end
        end
        S_LERP: begin
          pa     <= pa_adj;
          dlen   <= qlen - lo_ent.length;
          den    <= hi_ent.length - lo_ent.length;
          dp_neg <= dp[PARAM_W];
          dp_mag <= dp[PARAM_W] ? PARAM_W'(-dp) : dp[PARAM_W-1:0];
          state  <= S_MUL;
        end
        S_MUL: begin
          prod  <= prod_w;
          state <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            found_param <= dp_neg ? pa - quot : pa + quot;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/arc_length_parameter_lookup_tb.sv */
// self-checking testbench for arc_length_parameter_lookup: directed table, table fill, random
// command mix with its own table model for expected lookups; needs alps_pkg and the design

module arc_length_parameter_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alps_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  localparam int RANDOM_ITEMS  = 360;
  localparam int FILL_ENTRIES  = 150;
  localparam int CFG_INTERVAL  = 120;
  localparam int DIRECTED_ROWS = 25;
  localparam int DRAIN_LIMIT   = 5000;

  // opcode that the block treats as no operation
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [PARAM_W-1:0] param;
    logic [PATCH_W-1:0] patch;
    status_t            status;
  } result_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        len;
    logic [PARAM_W-1:0] param;
    logic [PATCH_W-1:0] patch;
    logic               typed;
    result_t            want;
  } stim_row_t;

  localparam result_t RES_ZERO  = '{param: '0, patch: '0, status: ST_OK};
  localparam result_t RES_RANGE = '{param: '0, patch: '0, status: ST_RANGE};
  localparam result_t RES_EMPTY = '{param: '0, patch: '0, status: ST_EMPTY};

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          opcode;
  logic signed [31:0]  arc_length;
  logic [PARAM_W-1:0]  entry_param;
  logic [PATCH_W-1:0]  entry_patch;
  logic                done;
  logic [PARAM_W-1:0]  found_param;
  logic [PATCH_W-1:0]  found_patch;
  logic [1:0]          status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [TOL_W-1:0]    cfg_data;

  arc_length_parameter_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .arc_length (arc_length),
    .entry_param(entry_param),
    .entry_patch(entry_patch),
    .done       (done),
    .found_param(found_param),
    .found_patch(found_patch),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // shadow copy of the lookup table and the tolerance register
  logic [LEN_W-1:0]   tab_len   [TABLE_DEPTH];
  logic [PARAM_W-1:0] tab_param [TABLE_DEPTH];
  logic [PATCH_W-1:0] tab_patch [TABLE_DEPTH];
  int                 tab_count;
  logic [TOL_W-1:0]   tol_model;

  result_t   pending_results [$];
  stim_row_t directed [DIRECTED_ROWS];

  bit idle_en;
  int mismatches;
  int commands_sent;
  int results_checked;
  int hits_ok;
  int hits_range;
  int hits_empty;
  int hits_full;
  int tol_writes;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("arc_length_parameter_lookup regression: fail");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // interpolated parameter between two bracketing entries
  function automatic logic [PARAM_W-1:0] blend(longint sought, int lo_i, int hi_i);
    longint la, lb, pa, pb, span, tol;
    la   = tab_len[lo_i];
    lb   = tab_len[hi_i];
    pa   = tab_param[lo_i];
    pb   = tab_param[hi_i];
    tol  = tol_model;
    span = lb - la;
    if (pa >= longint'(ONE_Q16) - tol && pa <= longint'(ONE_Q16) + tol) pa = 0;
    if (span <= 0) return pa[PARAM_W-1:0];
    pa = pa + ((sought - la) * (pb - pa)) / span;
    return pa[PARAM_W-1:0];
  endfunction

  function automatic result_t search_table(longint sought);
    result_t r;
    int lo, hi, mid, probe;
    longint lm;
    r = RES_RANGE;
    if (tab_count == 0) return RES_EMPTY;
    if (sought < 0 || sought > longint'(tab_len[tab_count-1]) || sought < longint'(tab_len[0]))
      return r;
    lo = 0;
    hi = tab_count - 1;
    for (probe = 0; probe < 64; probe++) begin
      if (lo > hi || hi >= tab_count) break;
      mid = lo + (hi - lo) / 2;
      lm  = tab_len[mid];
      if (lm == sought) begin
        r = '{param: tab_param[mid], patch: tab_patch[mid], status: ST_OK};
        return r;
      end
      if (lm > sought) begin
        if (mid == 0) break;
        if (longint'(tab_len[mid-1]) < sought) begin
          r = '{param: blend(sought, mid - 1, mid), patch: tab_patch[mid], status: ST_OK};
          return r;
        end
        hi = mid - 1;
      end else begin
        if (mid + 1 >= tab_count) break;
        if (longint'(tab_len[mid+1]) > sought) begin
          r = '{param: blend(sought, mid, mid + 1), patch: tab_patch[mid+1], status: ST_OK};
          return r;
        end
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  // updates the shadow table and returns the result the command should produce
  function automatic result_t apply_command(logic [1:0] op, logic signed [31:0] len,
                                            logic [PARAM_W-1:0] prm, logic [PATCH_W-1:0] pch);
    result_t            r;
    logic [LEN_W-1:0]   v;
    r = RES_ZERO;
    case (op)
      OP_CLEAR: tab_count = 0;
      OP_APPEND: begin
        if (tab_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          v = (len < 0) ? '0 : len[LEN_W-1:0];
          if (tab_count > 0 && v < tab_len[tab_count-1]) v = tab_len[tab_count-1];
          tab_len[tab_count]   = v;
          tab_param[tab_count] = (prm > ONE_Q16) ? ONE_Q16 : prm;
          tab_patch[tab_count] = pch;
          tab_count++;
        end
      end
      OP_QUERY: r = search_table(longint'(len));
      default: ;
    endcase
    case (r.status)
      ST_OK:    if (op == OP_QUERY) hits_ok++;
      ST_RANGE: hits_range++;
      ST_EMPTY: hits_empty++;
      ST_FULL:  hits_full++;
      default: ;
    endcase
    return r;
  endfunction

  // sender side: optional gap, then hold the command until busy is low at an edge
  task automatic issue(input logic [1:0] op, input logic [31:0] len,
                       input logic [PARAM_W-1:0] prm, input logic [PATCH_W-1:0] pch,
                       input bit typed = 1'b0, input result_t want = RES_ZERO);
    result_t r;
    int      gap;
    gap = idle_en ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    opcode      <= op;
    arc_length  <= len;
    entry_param <= prm;
    entry_patch <= pch;
    do @(posedge clk); while (busy);
    r = apply_command(op, len, prm, pch);
    pending_results.insert(pending_results.size(), typed ? want : r);
    commands_sent++;
  endtask

  task automatic drain_results();
    int w;
    @(negedge clk);
    start <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && pending_results.size() != 0; w++) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tol_model = v;
    tol_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // parameters biased toward the edges of the band around 1.0
  function automatic logic [PARAM_W-1:0] pick_param();
    longint band_v;
    case ($urandom_range(0, 5))
      0: begin
        band_v = longint'(tol_model) + $urandom_range(0, 2) - 1;
        band_v = ($urandom_range(0, 1) != 0) ? longint'(ONE_Q16) + band_v
                                             : longint'(ONE_Q16) - band_v;
        if (band_v < 0) band_v = 0;
        if (band_v > 131071) band_v = 131071;
        return band_v[PARAM_W-1:0];
      end
      1: return PARAM_W'($urandom_range(0, 131071));
      2: return ($urandom_range(0, 1) != 0) ? ONE_Q16 : '0;
      default: return PARAM_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [31:0] pick_query_length();
    int     i;
    longint lo_len, hi_len;
    if (tab_count == 0) return $urandom();
    i = $urandom_range(0, tab_count - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: return {1'b0, tab_len[i]};
      3, 4, 5, 6: begin
        lo_len = tab_len[i];
        hi_len = (i + 1 < tab_count) ? longint'(tab_len[i+1]) : lo_len;
        return 32'(lo_len + longint'($urandom_range(0, 32'(hi_len - lo_len))));
      end
      7: return 32'(longint'(tab_len[0]) - 1 - longint'($urandom_range(0, 255)));
      8: return 32'(longint'(tab_len[tab_count-1]) + 1 + longint'($urandom_range(0, 1000)));
      default: return $urandom();
    endcase
  endfunction

  task automatic append_run(input int n, input longint first_len, input int unsigned step_max);
    longint run_len;
    run_len = first_len;
    repeat (n) begin
      issue(OP_APPEND, 32'(run_len), pick_param(), PATCH_W'($urandom()));
      // equal lengths now and then
      if ($urandom_range(0, 7) != 0) run_len += longint'($urandom_range(0, step_max));
      if (run_len > 64'h7FFF_FFFF) run_len = 64'h7FFF_FFFF;
    end
  endtask

  task automatic query_run(input int n);
    repeat (n) issue(OP_QUERY, pick_query_length(), PARAM_W'($urandom()), PATCH_W'($urandom()));
  endtask

  task automatic run_sequence();
    int     kind, n;
    longint first_len;
    idle_en = ($urandom_range(0, 3) != 0);
    kind    = $urandom_range(0, 9);
    if (kind <= 6) begin
      // well-formed: clear, ascending appends, then lookups
      issue(OP_CLEAR, $urandom(), PARAM_W'($urandom()), PATCH_W'($urandom()));
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 40);
      first_len = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 32'h7FFF_FFFF))
                                              : longint'($urandom_range(0, 1000));
      append_run(n, first_len, 1 << $urandom_range(0, 22));
      query_run($urandom_range(n, 2 * n + 4));
    end else if (kind == 7) begin
      repeat (12) issue(2'($urandom()), $urandom(), PARAM_W'($urandom()), PATCH_W'($urandom()));
    end else if (kind == 8) begin
      // unordered and negative appends onto whatever is in the table
      repeat ($urandom_range(1, 8))
        issue(OP_APPEND, $urandom(), pick_param(), PATCH_W'($urandom()));
      query_run(6);
    end else begin
      query_run(10);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: param %0h patch %0h status %0d",
                                found_param, found_patch, status));
      end else begin
        want = pending_results.pop_front();
        if (found_param !== want.param)
          note_mismatch($sformatf("found_param %0h, expected %0h", found_param, want.param));
        if (found_patch !== want.patch)
          note_mismatch($sformatf("found_patch %0h, expected %0h", found_patch, want.patch));
        if (status !== want.status)
          note_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        results_checked++;
      end
    end
  end

  initial begin
    int i, base;
    int next_cfg;
    int tol_phase;
    rst         = 1'b1;
    start       = 1'b0;
    opcode      = OP_CLEAR;
    arc_length  = '0;
    entry_param = '0;
    entry_patch = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    tab_count   = 0;
    tol_model   = 16'd66;
    idle_en     = 1'b1;

    directed[0]  = '{OP_QUERY,  32'h0000_0000, 17'h00000, 8'h00, 1'b1, RES_EMPTY};
    directed[1]  = '{OP_NONE,   32'hFFFF_FFFF, 17'h1FFFF, 8'hFF, 1'b1, RES_ZERO};
    directed[2]  = '{OP_APPEND, 32'hFFFF_FFFB, 17'h00000, 8'h00, 1'b1, RES_ZERO};
    directed[3]  = '{OP_APPEND, 32'h0001_0000, 17'h10005, 8'hFF, 1'b1, RES_ZERO};
    directed[4]  = '{OP_APPEND, 32'h0000_8000, 17'h1FFFF, 8'h80, 1'b1, RES_ZERO};
    directed[5]  = '{OP_APPEND, 32'h7FFF_FFFF, 17'h0FFBE, 8'h5A, 1'b1, RES_ZERO};
    directed[6]  = '{OP_APPEND, 32'h7FFF_FFFF, 17'd12345, 8'h01, 1'b1, RES_ZERO};
    directed[7]  = '{OP_QUERY,  32'h0000_0000, 17'h00000, 8'h00, 1'b0, RES_ZERO};
    directed[8]  = '{OP_QUERY,  32'hFFFF_FFFF, 17'h00000, 8'h00, 1'b1, RES_RANGE};
    directed[9]  = '{OP_QUERY,  32'h8000_0000, 17'h00000, 8'h00, 1'b1, RES_RANGE};
    directed[10] = '{OP_QUERY,  32'h7FFF_FFFF, 17'h00000, 8'h00, 1'b0, RES_ZERO};
    directed[11] = '{OP_QUERY,  32'h0001_8000, 17'h00000, 8'h00, 1'b0, RES_ZERO};
    directed[12] = '{OP_QUERY,  32'h0000_4000, 17'h00000, 8'h00, 1'b0, RES_ZERO};
    directed[13] = '{OP_CLEAR,  32'h1234_5678, 17'h0ABCD, 8'h33, 1'b1, RES_ZERO};
    directed[14] = '{OP_QUERY,  32'h0000_0100, 17'h00000, 8'h00, 1'b1, RES_EMPTY};
    directed[15] = '{OP_APPEND, 32'h0000_0100, 17'd1000,  8'h03, 1'b1, RES_ZERO};
    directed[16] = '{OP_APPEND, 32'h0000_0200, 17'd500,   8'h04, 1'b1, RES_ZERO};
    directed[17] = '{OP_QUERY,  32'h0000_0180, 17'h00000, 8'h00, 1'b0, RES_ZERO};
    directed[18] = '{OP_QUERY,  32'h0000_0080, 17'h00000, 8'h00, 1'b1, RES_RANGE};
    directed[19] = '{OP_QUERY,  32'h0000_0201, 17'h00000, 8'h00, 1'b1, RES_RANGE};
    directed[20] = '{OP_QUERY,  32'h0000_0100, 17'h00000, 8'h00, 1'b0, RES_ZERO};
    // params driven on and just past the upper band edge, both clamp to 1.0; then a query past the end
    directed[21] = '{OP_APPEND, 32'h0000_0300, 17'h10042, 8'h07, 1'b1, RES_ZERO};
    directed[22] = '{OP_APPEND, 32'h0000_0400, 17'h10043, 8'h08, 1'b1, RES_ZERO};
    directed[23] = '{OP_QUERY,  32'h0000_0380, 17'h00000, 8'h00, 1'b0, RES_ZERO};
    directed[24] = '{OP_QUERY,  32'h0000_0480, 17'h00000, 8'h00, 1'b0, RES_ZERO};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++)
      issue(directed[i].op, directed[i].len, directed[i].param, directed[i].patch,
            directed[i].typed, directed[i].want);

    // build a deep table and search it
    write_tolerance(16'hFFFF);
    idle_en = 1'b0;
    issue(OP_CLEAR, '0, '0, '0);
    append_run(FILL_ENTRIES, 0, 5000);
    idle_en = 1'b1;
    query_run(40);

    base      = commands_sent;
    next_cfg  = 0;
    tol_phase = 0;
    while (commands_sent - base < RANDOM_ITEMS) begin
      if (commands_sent - base >= next_cfg) begin
        case (tol_phase % 5)
          0: write_tolerance(16'd0);
          1: write_tolerance(TOL_W'($urandom()));
          2: write_tolerance(16'd1);
          3: write_tolerance(16'd66);
          default: write_tolerance(TOL_W'($urandom_range(0, 200)));
        endcase
        tol_phase++;
        next_cfg += CFG_INTERVAL;
      end
      run_sequence();
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("ran %0d commands over %0d tolerance settings, %0d results checked",
             commands_sent, tol_writes + 1, results_checked);
    $display("lookups ok %0d, out of range %0d, empty table %0d, full table %0d",
             hits_ok, hits_range, hits_empty, hits_full);
    if (mismatches == 0) begin
      $display("arc_length_parameter_lookup regression: pass");
    end else begin
      $display("arc_length_parameter_lookup regression: fail");
    end
    $finish;
  end

endmodule
